>>> rtl/sphd_pkg.sv
// ----------------------------------------------------------------------------
// sphd_pkg
// Shared types and constants for the hashed SPH density/pressure block.
// ----------------------------------------------------------------------------
package sphd_pkg;

    // sizes and fixed-point format
    localparam int MAX_PARTICLES = 1024;
    localparam int NUM_BUCKETS   = 4096;
    localparam int FRAC_BITS     = 16;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] REG_KERNEL_COEF  = 3'd0;
    localparam logic [2:0] REG_RADIUS_SQ    = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE    = 3'd2;
    localparam logic [2:0] REG_SELF_DENSITY = 3'd3;
    localparam logic [2:0] REG_GAS_CONST    = 3'd4;
    localparam logic [2:0] REG_REST_DENSITY = 3'd5;

    localparam logic [31:0] HASH_KX = 32'd48424590;
    localparam logic [31:0] HASH_KY = 32'd62146215;
    localparam logic [31:0] HASH_KZ = 32'd86134585;

    localparam logic [62:0] PROD_CAP = 63'h4000_0000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_DIV,
        ST_HASH_MUL,
        ST_HASH_XOR,
        ST_INS_RD,
        ST_INS_WR,
        ST_Q_RDPOS,
        ST_Q_WAITPOS,
        ST_N_CELL,
        ST_N_HASH,
        ST_N_XOR,
        ST_N_RDHEAD,
        ST_N_HEAD,
        ST_P_RD,
        ST_P_DIST,
        ST_P_SUM,
        ST_P_T2,
        ST_P_T3A,
        ST_P_T3B,
        ST_P_K,
        ST_P_ACC,
        ST_FIN_SELF,
        ST_FIN_MUL,
        ST_FIN_OUT
    } state_t;

endpackage

>>> rtl/sph_hashed_density_pressure.sv
// ----------------------------------------------------------------------------
// sph_hashed_density_pressure
// Spatial hash grid with bucket chains in on-chip RAM; computes poly6 density
// and pressure of a stored particle over its 27 neighbor cells.
// ----------------------------------------------------------------------------
// Insert runs three cell divisions, one per axis, then hash and chain push;
// a query reads the stored position, divides it likewise, then hashes each of
// 27 neighbor cells and walks its chain. A query of an unloaded index gives
// its result in the next cycle; clear empties every bucket. One command at
// a time, busy high meanwhile; receiver cannot stall. Reset acts on registers
// only; after reset a clearing pass empties the bucket RAM with busy high.
module sph_hashed_density_pressure (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [9:0]  particle_index,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output logic        result_valid,
    output logic [30:0] density,
    output logic signed [31:0] pressure,
    output logic        status
);

    localparam int MAX_PARTICLES = sphd_pkg::MAX_PARTICLES;
    localparam int NUM_BUCKETS   = sphd_pkg::NUM_BUCKETS;
    localparam int FRAC_BITS     = sphd_pkg::FRAC_BITS;
    localparam int PW = $clog2(MAX_PARTICLES);
    localparam int LW = PW + 1;
    localparam int TW = $clog2(NUM_BUCKETS);
    localparam logic [LW-1:0] EMPTY = LW'(MAX_PARTICLES);
    localparam logic [LW-1:0] MAXP  = LW'(MAX_PARTICLES);

    // configuration
    logic [30:0] kcoef_reg, rsq_reg, csize_reg, selfd_reg, gas_reg, rest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kcoef_reg <= 31'd65536;
            rsq_reg   <= 31'd65536;
            csize_reg <= 31'd65536;
            selfd_reg <= 31'd0;
            gas_reg   <= 31'd65536;
            rest_reg  <= 31'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sphd_pkg::REG_KERNEL_COEF:  kcoef_reg <= cfg_data;
                sphd_pkg::REG_RADIUS_SQ:    rsq_reg   <= cfg_data;
                sphd_pkg::REG_CELL_SIZE:    csize_reg <= cfg_data;
                sphd_pkg::REG_SELF_DENSITY: selfd_reg <= cfg_data;
                sphd_pkg::REG_GAS_CONST:    gas_reg   <= cfg_data;
                sphd_pkg::REG_REST_DENSITY: rest_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // memories
    logic [LW-1:0] head_mem [NUM_BUCKETS];
    logic [LW-1:0] link_mem [MAX_PARTICLES];
    logic [95:0]   pos_mem  [MAX_PARTICLES];

    logic          head_we, link_we, pos_we;
    logic [TW-1:0] head_waddr, head_raddr;
    logic [LW-1:0] head_wdata, head_rdata;
    logic [PW-1:0] link_waddr, link_raddr, pos_waddr, pos_raddr;
    logic [LW-1:0] link_wdata, link_rdata;
    logic [95:0]   pos_wdata, pos_rdata;

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        head_rdata <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        link_rdata <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        pos_rdata <= pos_mem[pos_raddr];
    end

    // datapath registers
    sphd_pkg::state_t state_reg, state_next;
    logic [TW-1:0] clr_reg, clr_next;
    logic [LW-1:0] count_reg, count_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [95:0]   pos_reg, pos_next;          // own position
    logic [PW-1:0] idx_reg, idx_next;
    // restoring divider, one quotient bit per cycle, one axis at a time
    logic [1:0]    axis_reg, axis_next;
    logic [5:0]    dstep_reg, dstep_next;
    logic [31:0]   dquo_reg, dquo_next;
    logic [31:0]   drem_reg, drem_next;
    logic [31:0]   dnum_reg, dnum_next;
    logic [95:0]   cell_reg, cell_next;        // own cell
    logic [95:0]   hprod_reg, hprod_next;
    logic [TW-1:0] bkt_reg, bkt_next;
    logic [4:0]    nb_reg, nb_next;            // neighbor 0..26
    logic [1:0]    ndx_reg, ndx_next, ndy_reg, ndy_next, ndz_reg, ndz_next;
    logic [95:0]   ncell_reg, ncell_next;
    logic [LW-1:0] j_reg, j_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic [95:0]   ppos_reg, ppos_next;
    logic [LW-1:0] plink_reg, plink_next;
    logic [63:0]   sq_reg [3];
    logic [63:0]   sq_next [3];
    logic [2:0]    sqi_reg, sqi_next;
    logic [49:0]   d2_reg, d2_next;
    logic [63:0]   t_reg, t_next, t2_reg, t2_next;
    logic [63:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [62:0]   t3_reg, t3_next, term_reg, term_next;
    logic          hit_reg, hit_next;
    logic [30:0]   acc_reg, acc_next;
    logic [62:0]   pprod_reg, pprod_next;
    logic          neg_reg, neg_next;
    logic          rv_reg, rv_next;
    logic [30:0]   dens_reg, dens_next;
    logic [31:0]   pres_reg, pres_next;
    logic          stat_reg, stat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sphd_pkg::ST_CLR;
            clr_reg   <= '0;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;     pos_reg <= pos_next;     idx_reg <= idx_next;
        axis_reg <= axis_next;   dstep_reg <= dstep_next; dquo_reg <= dquo_next;
        drem_reg <= drem_next;   dnum_reg <= dnum_next;   cell_reg <= cell_next;
        hprod_reg <= hprod_next; bkt_reg <= bkt_next;     nb_reg <= nb_next;
        ndx_reg <= ndx_next;     ndy_reg <= ndy_next;     ndz_reg <= ndz_next;
        ncell_reg <= ncell_next; j_reg <= j_next;         steps_reg <= steps_next;
        ppos_reg <= ppos_next;   plink_reg <= plink_next; sqi_reg <= sqi_next;
        sq_reg[0] <= sq_next[0]; sq_reg[1] <= sq_next[1]; sq_reg[2] <= sq_next[2];
        d2_reg <= d2_next;       t_reg <= t_next;         t2_reg <= t2_next;
        lo_reg <= lo_next;       hi_reg <= hi_next;       t3_reg <= t3_next;
        term_reg <= term_next;   hit_reg <= hit_next;     acc_reg <= acc_next;
        pprod_reg <= pprod_next; neg_reg <= neg_next;     dens_reg <= dens_next;
        pres_reg <= pres_next;   stat_reg <= stat_next;
    end

    // helpers
    logic [31:0] csz;
    logic [31:0] axis_val;
    logic [32:0] dtrial;
    logic [31:0] cell_signed;
    logic [31:0] hx;
    logic [63:0] lo_shift;
    logic [63:0] v_sum;
    logic [31:0] dsel_a, dsel_b;
    logic [32:0] dsub;
    logic [31:0] dabs;
    logic [31:0] dens_full;
    logic [32:0] pd;
    logic [31:0] pdabs;

    assign csz = (csize_reg == 31'd0) ? 32'd1 : {1'b0, csize_reg};

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    axis_val = pos_reg[31:0];
            2'd1:    axis_val = pos_reg[63:32];
            default: axis_val = pos_reg[95:64];
        endcase
    end
    assign dtrial = {drem_reg, dnum_reg[31]} - {1'b0, csz};
    assign cell_signed = axis_val[31] ? (~dquo_reg + 32'd1) : dquo_reg;
    assign hx = hprod_reg[31:0] ^ hprod_reg[63:32] ^ hprod_reg[95:64];

    always_comb
    begin
        unique case (sqi_reg[1:0])
            2'd0:    begin dsel_a = ppos_reg[31:0];  dsel_b = pos_reg[31:0];  end
            2'd1:    begin dsel_a = ppos_reg[63:32]; dsel_b = pos_reg[63:32]; end
            default: begin dsel_a = ppos_reg[95:64]; dsel_b = pos_reg[95:64]; end
        endcase
    end
    assign dsub = {dsel_a[31], dsel_a} - {dsel_b[31], dsel_b};
    assign dabs = dsub[32] ? 32'((~dsub) + 33'd1) : dsub[31:0];

    assign lo_shift = lo_reg >> FRAC_BITS;
    assign v_sum    = (hi_reg << (32 - FRAC_BITS)) + lo_shift;

    assign dens_full = {1'b0, acc_reg} + {1'b0, selfd_reg};
    assign pd    = {2'b0, dens_reg} - {2'b0, rest_reg};
    assign pdabs = pd[32] ? 32'((~pd) + 33'd1) : pd[31:0];

    function automatic logic [62:0] sat_mul(input logic [63:0] hi, input logic [63:0] v);
        logic [62:0] r;
        if ((hi >> (30 + FRAC_BITS)) != 64'd0 || v > {1'b0, sphd_pkg::PROD_CAP})
            r = sphd_pkg::PROD_CAP;
        else
            r = v[62:0];
        return r;
    endfunction

    // control
    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;       count_next = count_reg;   cmd_next = cmd_reg;
        pos_next = pos_reg;       idx_next = idx_reg;       axis_next = axis_reg;
        dstep_next = dstep_reg;   dquo_next = dquo_reg;     drem_next = drem_reg;
        dnum_next = dnum_reg;     cell_next = cell_reg;     hprod_next = hprod_reg;
        bkt_next = bkt_reg;       nb_next = nb_reg;         ndx_next = ndx_reg;
        ndy_next = ndy_reg;       ndz_next = ndz_reg;       ncell_next = ncell_reg;
        j_next = j_reg;           steps_next = steps_reg;   ppos_next = ppos_reg;
        plink_next = plink_reg;   sqi_next = sqi_reg;       d2_next = d2_reg;
        sq_next[0] = sq_reg[0];   sq_next[1] = sq_reg[1];   sq_next[2] = sq_reg[2];
        t_next = t_reg;           t2_next = t2_reg;         lo_next = lo_reg;
        hi_next = hi_reg;         t3_next = t3_reg;         term_next = term_reg;
        hit_next = hit_reg;       acc_next = acc_reg;       pprod_next = pprod_reg;
        neg_next = neg_reg;       dens_next = dens_reg;     pres_next = pres_reg;
        stat_next = stat_reg;     rv_next = 1'b0;
        head_we = 1'b0; head_waddr = clr_reg; head_wdata = EMPTY; head_raddr = bkt_reg;
        link_we = 1'b0; link_waddr = count_reg[PW-1:0]; link_wdata = head_rdata;
        link_raddr = j_reg[PW-1:0];
        pos_we = 1'b0;  pos_waddr = count_reg[PW-1:0]; pos_wdata = pos_reg;
        pos_raddr = j_reg[PW-1:0];

        unique case (state_reg)
            sphd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    pos_next = {pos_z, pos_y, pos_x};
                    idx_next = particle_index[PW-1:0];
                    axis_next = 2'd0;
                    dstep_next = '0;
                    drem_next = '0;
                    dnum_next = pos_x[31] ? (~pos_x + 32'd1) : pos_x;
                    unique case (command)
                        sphd_pkg::CMD_CLEAR:
                        begin
                            clr_next = '0;
                            state_next = sphd_pkg::ST_CLR;
                        end
                        sphd_pkg::CMD_INSERT:
                            if (count_reg < MAXP)
                                state_next = sphd_pkg::ST_DIV;
                        sphd_pkg::CMD_QUERY:
                        begin
                            if ({1'b0, particle_index} >= 11'(count_reg) ||
                                32'(particle_index) >= 32'(MAX_PARTICLES))
                            begin
                                rv_next = 1'b1;
                                dens_next = '0;
                                pres_next = '0;
                                stat_next = 1'b1;
                            end
                            else
                            begin
                                j_next = {1'b0, particle_index[PW-1:0]};
                                state_next = sphd_pkg::ST_Q_RDPOS;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            sphd_pkg::ST_CLR:
            begin
                head_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                count_next = '0;
                if (clr_reg == TW'(NUM_BUCKETS - 1))
                    state_next = sphd_pkg::ST_IDLE;
            end

            sphd_pkg::ST_Q_RDPOS:
                state_next = sphd_pkg::ST_Q_WAITPOS;

            sphd_pkg::ST_Q_WAITPOS:
            begin
                pos_next = pos_rdata;
                dnum_next = pos_rdata[31] ? (~pos_rdata[31:0] + 32'd1) : pos_rdata[31:0];
                state_next = sphd_pkg::ST_DIV;
            end

            // cell = trunc(p / cell_size), one quotient bit a cycle
            sphd_pkg::ST_DIV:
            begin
                if (dstep_reg == 6'd32)
                begin
                    unique case (axis_reg)
                        2'd0:    cell_next[31:0]  = cell_signed;
                        2'd1:    cell_next[63:32] = cell_signed;
                        default: cell_next[95:64] = cell_signed;
                    endcase
                    dstep_next = '0;
                    drem_next = '0;
                    axis_next = axis_reg + 2'd1;
                    unique case (axis_reg)
                        2'd0: dnum_next = pos_reg[63] ? (~pos_reg[63:32] + 32'd1)
                                                      : pos_reg[63:32];
                        default: dnum_next = pos_reg[95] ? (~pos_reg[95:64] + 32'd1)
                                                         : pos_reg[95:64];
                    endcase
                    if (axis_reg == 2'd2)
                    begin
                        if (cmd_reg == sphd_pkg::CMD_INSERT)
                            state_next = sphd_pkg::ST_HASH_MUL;
                        else
                        begin
                            nb_next = '0; ndx_next = '0; ndy_next = '0; ndz_next = '0;
                            acc_next = '0;
                            state_next = sphd_pkg::ST_N_CELL;
                        end
                    end
                end
                else
                begin
                    dnum_next = {dnum_reg[30:0], 1'b0};
                    dstep_next = dstep_reg + 6'd1;
                    if (!dtrial[32])
                    begin
                        drem_next = dtrial[31:0];
                        dquo_next = {dquo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        drem_next = {drem_reg[30:0], dnum_reg[31]};
                        dquo_next = {dquo_reg[30:0], 1'b0};
                    end
                end
            end

            sphd_pkg::ST_HASH_MUL:
            begin
                hprod_next = {32'(cell_reg[95:64] * sphd_pkg::HASH_KZ),
                              32'(cell_reg[63:32] * sphd_pkg::HASH_KY),
                              32'(cell_reg[31:0]  * sphd_pkg::HASH_KX)};
                state_next = sphd_pkg::ST_HASH_XOR;
            end

            sphd_pkg::ST_HASH_XOR:
            begin
                bkt_next = hx[TW-1:0];
                state_next = sphd_pkg::ST_INS_RD;
            end

            sphd_pkg::ST_INS_RD:
                state_next = sphd_pkg::ST_INS_WR;

            // push onto chain: link <= old head, head <= n
            sphd_pkg::ST_INS_WR:
            begin
                link_we = 1'b1;
                pos_we = 1'b1;
                head_we = 1'b1;
                head_waddr = bkt_reg;
                head_wdata = count_reg;
                count_next = count_reg + 1'b1;
                state_next = sphd_pkg::ST_IDLE;
            end

            sphd_pkg::ST_N_CELL:
            begin
                ncell_next = {cell_reg[95:64] + {30'd0, ndz_reg} - 32'd1,
                              cell_reg[63:32] + {30'd0, ndy_reg} - 32'd1,
                              cell_reg[31:0]  + {30'd0, ndx_reg} - 32'd1};
                state_next = sphd_pkg::ST_N_HASH;
            end

            sphd_pkg::ST_N_HASH:
            begin
                hprod_next = {32'(ncell_reg[95:64] * sphd_pkg::HASH_KZ),
                              32'(ncell_reg[63:32] * sphd_pkg::HASH_KY),
                              32'(ncell_reg[31:0]  * sphd_pkg::HASH_KX)};
                state_next = sphd_pkg::ST_N_XOR;
            end

            sphd_pkg::ST_N_XOR:
            begin
                bkt_next = hx[TW-1:0];
                state_next = sphd_pkg::ST_N_RDHEAD;
            end

            sphd_pkg::ST_N_RDHEAD:
                state_next = sphd_pkg::ST_N_HEAD;

            sphd_pkg::ST_N_HEAD:
            begin
                j_next = head_rdata;
                steps_next = '0;
                state_next = sphd_pkg::ST_P_RD;
            end

            // walk one chain entry; pos and link read in parallel
            sphd_pkg::ST_P_RD:
            begin
                if (j_reg >= MAXP || steps_reg >= MAXP)
                begin
                    nb_next = nb_reg + 5'd1;
                    if (ndz_reg == 2'd2)
                    begin
                        ndz_next = '0;
                        if (ndy_reg == 2'd2)
                        begin
                            ndy_next = '0;
                            ndx_next = ndx_reg + 2'd1;
                        end
                        else
                            ndy_next = ndy_reg + 2'd1;
                    end
                    else
                        ndz_next = ndz_reg + 2'd1;
                    if (nb_reg == 5'd26)
                        state_next = sphd_pkg::ST_FIN_SELF;
                    else
                        state_next = sphd_pkg::ST_N_CELL;
                end
                else
                    state_next = sphd_pkg::ST_P_DIST;
            end

            sphd_pkg::ST_P_DIST:
            begin
                ppos_next = pos_rdata;
                plink_next = link_rdata;
                sqi_next = '0;
                state_next = sphd_pkg::ST_P_SUM;
            end

            // one axis square per cycle, then sum
            sphd_pkg::ST_P_SUM:
            begin
                if (sqi_reg == 3'd3)
                begin
                    d2_next = 50'(sq_reg[0]) + 50'(sq_reg[1]) + 50'(sq_reg[2]);
                    state_next = sphd_pkg::ST_P_T2;
                end
                else
                begin
                    sq_next[sqi_reg[1:0]] = (64'(dabs) * 64'(dabs)) >> FRAC_BITS;
                    sqi_next = sqi_reg + 3'd1;
                end
            end

            sphd_pkg::ST_P_T2:
            begin
                hit_next = (j_reg[PW-1:0] != idx_reg) && (d2_reg < 50'(rsq_reg));
                t_next = 64'(rsq_reg) - 64'(d2_reg);
                state_next = sphd_pkg::ST_P_T3A;
            end

            sphd_pkg::ST_P_T3A:
            begin
                t2_next = (64'(t_reg[31:0]) * 64'(t_reg[31:0])) >> FRAC_BITS;
                state_next = sphd_pkg::ST_P_T3B;
            end

            sphd_pkg::ST_P_T3B:
            begin
                lo_next = 64'(t2_reg[31:0]) * 64'(t_reg[31:0]);
                hi_next = 64'(t2_reg[63:32]) * 64'(t_reg[31:0]);
                state_next = sphd_pkg::ST_P_K;
            end

            sphd_pkg::ST_P_K:
            begin
                t3_next = sat_mul(hi_reg, v_sum);
                state_next = sphd_pkg::ST_P_ACC;
                sqi_next = 3'd4;
            end

            sphd_pkg::ST_P_ACC:
            begin
                if (sqi_reg == 3'd4)
                begin
                    lo_next = 64'(t3_reg[31:0]) * 64'(kcoef_reg);
                    hi_next = 64'(t3_reg[62:32]) * 64'(kcoef_reg);
                    sqi_next = 3'd5;
                end
                else if (sqi_reg == 3'd5)
                begin
                    term_next = sat_mul(hi_reg, v_sum);
                    sqi_next = 3'd6;
                end
                else
                begin
                    if (hit_reg)
                    begin
                        if (64'(acc_reg) + 64'(term_reg) > 64'h7FFF_FFFF)
                            acc_next = '1;
                        else
                            acc_next = 31'(64'(acc_reg) + 64'(term_reg));
                    end
                    j_next = plink_reg;
                    steps_next = steps_reg + 1'b1;
                    state_next = sphd_pkg::ST_P_RD;
                end
            end

            sphd_pkg::ST_FIN_SELF:
            begin
                dens_next = dens_full[31] ? 31'h7FFF_FFFF : dens_full[30:0];
                state_next = sphd_pkg::ST_FIN_MUL;
            end

            sphd_pkg::ST_FIN_MUL:
            begin
                pprod_next = 63'((64'(gas_reg) * 64'(pdabs)) >> FRAC_BITS);
                neg_next = pd[32];
                state_next = sphd_pkg::ST_FIN_OUT;
            end

            sphd_pkg::ST_FIN_OUT:
            begin
                if (neg_reg)
                    pres_next = (pprod_reg > 63'h8000_0000) ? 32'h8000_0000
                                : 32'((~pprod_reg) + 63'd1);
                else
                    pres_next = (pprod_reg > 63'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                : pprod_reg[31:0];
                stat_next = 1'b0;
                rv_next = 1'b1;
                state_next = sphd_pkg::ST_IDLE;
            end

            default:
                state_next = sphd_pkg::ST_IDLE;
        endcase
    end

    assign busy         = (state_reg != sphd_pkg::ST_IDLE);
    assign result_valid = rv_reg;
    assign density      = dens_reg;
    assign pressure     = pres_reg;
    assign status       = stat_reg;

    // checks
    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= MAXP;
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("particle count overflow");

    property p_result_idle;
        @(posedge clk) disable iff (!rst_n) result_valid |-> !busy || !$past(busy);
    endproperty
    a_result_idle: assert property (p_result_idle) else $error("result while working");

    property p_insert_count;
        @(posedge clk) disable iff (!rst_n)
            state_reg == sphd_pkg::ST_INS_WR |=> count_reg == $past(count_reg) + 1'b1;
    endproperty
    a_insert_count: assert property (p_insert_count) else $error("insert lost count");

endmodule

>>> tb/sv/sph_hashed_density_pressure_test.sv
// ----------------------------------------------------------------------------
// sph_hashed_density_pressure_test
// Self-checking bench for the hashed SPH density/pressure block. A queue-fed
// driver issues clear/insert/query commands, a behavioral predictor tracks the
// bucket chains and computes density and pressure per query, and a monitor
// compares every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module sph_hashed_density_pressure_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PART   = sphd_pkg::MAX_PARTICLES;
    localparam int NUM_BUCKET = sphd_pkg::NUM_BUCKETS;
    localparam int FRAC       = sphd_pkg::FRAC_BITS;
    localparam int STALL_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [10:0] EMPTY_LINK = 11'd1024;
    localparam logic [63:0] SAT_CAP = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LOW32 = 64'hFFFF_FFFF;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [9:0]  idx;
    } cmd_item_t;

    typedef struct {
        logic [30:0] dens;
        logic [31:0] pres;
        logic        stat;
    } density_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [9:0]  particle_index;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [30:0] cfg_data;
    logic        result_valid;
    logic [30:0] density;
    logic signed [31:0] pressure;
    logic        status;

    sph_hashed_density_pressure DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .particle_index(particle_index), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .density(density),
        .pressure(pressure), .status(status)
    );

    // predictor state
    logic [10:0] bucket_head [NUM_BUCKET];
    logic [10:0] chain_next [NUM_PART];
    logic [31:0] stored_pos [NUM_PART][3];
    int unsigned stored_count;
    logic [30:0] reg_val [6];

    cmd_item_t       pending_cmds[$];
    density_result_t expected_results[$];
    cmd_item_t       held_cmd;
    int unsigned     transfers;
    int unsigned     fail_count;
    int unsigned     quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] cell_of(logic [31:0] p);
        longint cs;
        cs = (reg_val[sphd_pkg::REG_CELL_SIZE] != 0)
             ? longint'(reg_val[sphd_pkg::REG_CELL_SIZE]) : 64'sd1;
        return 32'(longint'(signed'(p)) / cs);
    endfunction

    function automatic logic [11:0] bucket_of(logic [31:0] cx, logic [31:0] cy,
                                              logic [31:0] cz);
        logic [31:0] hx, hy, hz;
        hx = cx * sphd_pkg::HASH_KX;
        hy = cy * sphd_pkg::HASH_KY;
        hz = cz * sphd_pkg::HASH_KZ;
        return 12'((hx ^ hy ^ hz) % NUM_BUCKET);
    endfunction

    // (a*b)>>FRAC with saturation at 2^62
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b);
        logic [63:0] lo, hi, v;
        lo = (a & LOW32) * b;
        hi = (a >> 32) * b;
        if ((hi >> (30 + FRAC)) != 0)
            return SAT_CAP;
        v = (hi << (32 - FRAC)) + (lo >> FRAC);
        return (v > SAT_CAP) ? SAT_CAP : v;
    endfunction

    function automatic logic [63:0] axis_dist_sq(logic [31:0] a, logic [31:0] b);
        longint d;
        logic [63:0] m;
        d = longint'(signed'(a)) - longint'(signed'(b));
        m = (d < 0) ? 64'(-d) : 64'(d);
        return (m * m) >> FRAC;
    endfunction

    // density/pressure of one stored particle
    function automatic density_result_t query_density(int unsigned qi);
        density_result_t r;
        logic [31:0] cx, cy, cz;
        logic [63:0] acc, d2, t, t2, t3, mag, prod, rsq;
        logic [10:0] j;
        int unsigned steps;
        longint diff;
        acc = 0;
        rsq = 64'(reg_val[sphd_pkg::REG_RADIUS_SQ]);
        if (qi >= stored_count)
        begin
            r.dens = '0;
            r.pres = '0;
            r.stat = 1'b1;
            return r;
        end
        cx = cell_of(stored_pos[qi][0]);
        cy = cell_of(stored_pos[qi][1]);
        cz = cell_of(stored_pos[qi][2]);
        for (int dx = 0; dx < 3; dx++)
            for (int dy = 0; dy < 3; dy++)
                for (int dz = 0; dz < 3; dz++)
                begin
                    j = bucket_head[bucket_of(cx + 32'(dx) - 32'd1, cy + 32'(dy) - 32'd1,
                                              cz + 32'(dz) - 32'd1)];
                    steps = 0;
                    while (j < EMPTY_LINK && steps < NUM_PART)
                    begin
                        d2 = axis_dist_sq(stored_pos[j][0], stored_pos[qi][0])
                           + axis_dist_sq(stored_pos[j][1], stored_pos[qi][1])
                           + axis_dist_sq(stored_pos[j][2], stored_pos[qi][2]);
                        if (j != qi && d2 < rsq)
                        begin
                            t = rsq - d2;
                            t2 = (t * t) >> FRAC;
                            t3 = scaled_product(t2, t);
                            acc = acc + scaled_product(t3,
                                      64'(reg_val[sphd_pkg::REG_KERNEL_COEF]));
                            if (acc > 64'h7FFF_FFFF)
                                acc = 64'h7FFF_FFFF;
                        end
                        j = chain_next[j];
                        steps++;
                    end
                end
        acc = acc + 64'(reg_val[sphd_pkg::REG_SELF_DENSITY]);
        if (acc > 64'h7FFF_FFFF)
            acc = 64'h7FFF_FFFF;
        r.dens = acc[30:0];
        diff = longint'(acc) - longint'(reg_val[sphd_pkg::REG_REST_DENSITY]);
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        prod = (64'(reg_val[sphd_pkg::REG_GAS_CONST]) * mag) >> FRAC;
        if (diff < 0)
            r.pres = (prod > 64'h8000_0000) ? 32'h8000_0000 : 32'(-prod);
        else
            r.pres = (prod > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : prod[31:0];
        r.stat = 1'b0;
        return r;
    endfunction

    // update predictor for one accepted command
    task automatic apply_command(cmd_item_t it);
        logic [11:0] b;
        case (it.cmd)
            sphd_pkg::CMD_CLEAR:
            begin
                foreach (bucket_head[i]) bucket_head[i] = EMPTY_LINK;
                stored_count = 0;
            end
            sphd_pkg::CMD_INSERT:
            begin
                if (stored_count < NUM_PART)
                begin
                    stored_pos[stored_count][0] = it.px;
                    stored_pos[stored_count][1] = it.py;
                    stored_pos[stored_count][2] = it.pz;
                    b = bucket_of(cell_of(it.px), cell_of(it.py), cell_of(it.pz));
                    chain_next[stored_count] = bucket_head[b];
                    bucket_head[b] = 11'(stored_count);
                    stored_count++;
                end
            end
            sphd_pkg::CMD_QUERY:
                expected_results.push_back(query_density(it.idx));
            default: ;
        endcase
    endtask

    // sender idle rate rises over the run, then drops to zero
    function automatic bit sender_idles();
        if (transfers < 180)
            return $urandom_range(99) < 34;
        if (transfers < 360)
            return $urandom_range(99) < 68;
        return 1'b0;
    endfunction

    // driver: one transfer per edge with start high and busy low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_command(held_cmd);
                transfers++;
            end
            if (!start || !busy)
            begin
                if (pending_cmds.size() != 0 && !sender_idles())
                begin
                    held_cmd = pending_cmds.pop_front();
                    start <= 1'b1;
                    command <= held_cmd.cmd;
                    pos_x <= held_cmd.px;
                    pos_y <= held_cmd.py;
                    pos_z <= held_cmd.pz;
                    particle_index <= held_cmd.idx;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles <= ((start && !busy) || result_valid) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result density %h pressure %h status %b",
                             $time, density, pressure, status);
                    fail_count++;
                end
                else
                begin
                    density_result_t e;
                    e = expected_results.pop_front();
                    if (density !== e.dens)
                    begin
                        $display("%0t density expected %h actual %h", $time, e.dens, density);
                        fail_count++;
                    end
                    if (pressure !== e.pres)
                    begin
                        $display("%0t pressure expected %h actual %h", $time, e.pres, pressure);
                        fail_count++;
                    end
                    if (status !== e.stat)
                    begin
                        $display("%0t status expected %b actual %b", $time, e.stat, status);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic push_cmd(logic [1:0] c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [9:0] i);
        cmd_item_t it;
        it.cmd = c;
        it.px = x;
        it.py = y;
        it.pz = z;
        it.idx = i;
        pending_cmds.push_back(it);
    endtask

    task automatic push_insert(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        push_cmd(sphd_pkg::CMD_INSERT, x, y, z, 10'($urandom));
    endtask

    task automatic push_query(logic [9:0] i);
        push_cmd(sphd_pkg::CMD_QUERY, $urandom, $urandom, $urandom, i);
    endtask

    // wait for all transfers and results, then for the block to go idle
    task automatic drain();
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx <= sphd_pkg::REG_REST_DENSITY)
            reg_val[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one random cluster with a random setting
    task automatic random_phase(bit extreme);
        int unsigned cell_edge, span, n;
        logic [31:0] ctr [3];
        logic [63:0] rsq;
        cell_edge = $urandom_range(1 << 18, 1 << 12);
        rsq = (64'(cell_edge) * 64'(cell_edge)) >> FRAC;
        write_reg(sphd_pkg::REG_CELL_SIZE,
                  extreme && $urandom_range(1) ? 31'd0 : 31'(cell_edge));
        write_reg(sphd_pkg::REG_RADIUS_SQ,
                  extreme ? 31'h7FFF_FFFF : 31'(rsq + 64'($urandom_range(7))));
        write_reg(sphd_pkg::REG_KERNEL_COEF,
                  extreme ? 31'h7FFF_FFFF : 31'($urandom_range(1 << 20)));
        write_reg(sphd_pkg::REG_SELF_DENSITY,
                  extreme ? 31'h7FFF_FFFF : 31'($urandom_range(1 << 18)));
        write_reg(sphd_pkg::REG_GAS_CONST,
                  $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(1 << 18)));
        write_reg(sphd_pkg::REG_REST_DENSITY, extreme ? 31'd0 : 31'($urandom));
        span = (reg_val[sphd_pkg::REG_CELL_SIZE] == 0) ? 4 : cell_edge * 2;
        for (int a = 0; a < 3; a++)
            ctr[a] = $urandom;
        push_cmd(sphd_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, 10'($urandom));
        n = $urandom_range(40, 4);
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0: push_insert($urandom, $urandom, $urandom);
                1: push_cmd(sphd_pkg::CMD_UNUSED, $urandom, $urandom, $urandom,
                            10'($urandom));
                default:
                    push_insert(ctr[0] + $urandom_range(2 * span) - span,
                                ctr[1] + $urandom_range(2 * span) - span,
                                ctr[2] + $urandom_range(2 * span) - span);
            endcase
            if ($urandom_range(2) == 0)
                push_query(10'($urandom_range(k + 2)));
        end
        for (int k = 0; k < 12; k++)
            push_query(10'($urandom_range(n + 2)));
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = sphd_pkg::CMD_CLEAR;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        particle_index = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        transfers = 0;
        fail_count = 0;
        quiet_cycles = 0;
        stored_count = 0;
        foreach (bucket_head[i]) bucket_head[i] = EMPTY_LINK;
        foreach (chain_next[i]) chain_next[i] = '0;
        foreach (stored_pos[i, a]) stored_pos[i][a] = '0;
        reg_val[sphd_pkg::REG_KERNEL_COEF] = 31'd65536;
        reg_val[sphd_pkg::REG_RADIUS_SQ] = 31'd65536;
        reg_val[sphd_pkg::REG_CELL_SIZE] = 31'd65536;
        reg_val[sphd_pkg::REG_SELF_DENSITY] = 31'd0;
        reg_val[sphd_pkg::REG_GAS_CONST] = 31'd65536;
        reg_val[sphd_pkg::REG_REST_DENSITY] = 31'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed: reset settings, close neighbors, field extremes
        push_insert(32'd0, 32'd0, 32'd0);
        push_insert(32'd32768, 32'd0, 32'd0);
        push_insert(32'd0, 32'd16384, 32'hFFFF_C000);
        push_insert(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_insert(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_insert(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
        for (int q = 0; q < 6; q++)
            push_query(10'(q));
        push_query(10'd100);
        push_query(10'd1023);
        push_cmd(sphd_pkg::CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
        push_cmd(sphd_pkg::CMD_CLEAR, '0, '0, '0, '0);
        push_query(10'd0);
        drain();

        // saturation of density and pressure, unknown register index
        write_reg(sphd_pkg::REG_KERNEL_COEF, 31'h7FFF_FFFF);
        write_reg(sphd_pkg::REG_SELF_DENSITY, 31'd1000);
        write_reg(sphd_pkg::REG_GAS_CONST, 31'h7FFF_FFFF);
        write_reg(3'd6, 31'h1234_5678);
        write_reg(3'd7, 31'h7FFF_FFFF);
        push_insert(32'd0, 32'd0, 32'd0);
        push_insert(32'd100, 32'd0, 32'd0);
        push_insert(32'd0, 32'd200, 32'd0);
        push_query(10'd0);
        push_query(10'd2);
        drain();
        write_reg(sphd_pkg::REG_REST_DENSITY, 31'h7FFF_FFFF);
        write_reg(sphd_pkg::REG_KERNEL_COEF, 31'd0);
        push_query(10'd1);
        drain();

        // cell size changed after chains were built, then zero cell size
        write_reg(sphd_pkg::REG_CELL_SIZE, 31'd1);
        write_reg(sphd_pkg::REG_REST_DENSITY, 31'd0);
        write_reg(sphd_pkg::REG_KERNEL_COEF, 31'd65536);
        write_reg(sphd_pkg::REG_GAS_CONST, 31'd65536);
        push_query(10'd0);
        push_query(10'd1);
        push_cmd(sphd_pkg::CMD_CLEAR, '0, '0, '0, '0);
        drain();
        write_reg(sphd_pkg::REG_CELL_SIZE, 31'd0);
        write_reg(sphd_pkg::REG_RADIUS_SQ, 31'd4);
        push_insert(32'd5, 32'd5, 32'd5);
        push_insert(32'd6, 32'd5, 32'd5);
        push_insert(32'd4, 32'd4, 32'd6);
        push_query(10'd0);
        push_query(10'd2);
        drain();

        // random clusters
        for (int ph = 0; ph < 6; ph++)
            random_phase(ph == 2);

        for (int ph = 0; ph < 6; ph++)
            random_phase(ph == 4);

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sph_hashed_density_pressure.f
rtl/sphd_pkg.sv
rtl/sph_hashed_density_pressure.sv
tb/sv/sph_hashed_density_pressure_test.sv
